@@ hdl/fh64_pkg.sv @@
// shared types and constants for the fasthash64 word stream block
// no dependencies; imported by every module under hdl
package fh64_pkg;

   localparam int unsigned REQ_DATA_W = 104;
   localparam int unsigned RSP_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [CSR_ADDR_W-1:0] ADDR_SEED = 3'd0;

   localparam logic [63:0] HASH_M    = 64'h880355f21e6d1965;
   localparam logic [63:0] HASH_MIXK = 64'h2127599bf4325c37;
   localparam int unsigned SHIFT_A = 23;
   localparam int unsigned SHIFT_B = 47;

   // one classified request as it waits between front and back
   typedef struct packed {
      logic [63:0] word;
      logic        absorb;
      logic        first;
      logic        last;
      logic [31:0] length;
   } fh64_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_MIX,
      ST_ACC,
      ST_FIN
   } fh64_state_type;

endpackage

@@ hdl/fasthash64_word_stream.sv @@
// top level of the fasthash64 word stream block: csr port, intake, queue, engine
// depends on fh64_pkg, fh64_front, fh64_queue, fh64_back
//
// Computes the 64-bit fasthash of a message sent as little-endian 64-bit words.
// A request marked first (req_tuser) seeds the state with seed ^ (length * m);
// every request with a nonzero byte count absorbs its low bytes, and the request
// marked last (req_tlast) produces one response carrying the final hash.
// Counts above 8 act as 8; a count of 0 absorbs nothing, so the empty message is
// a single first+last request with count 0. Requests without first continue from
// the current state. The seed register sits at byte address 0 of the csr port and
// should only be written while no message is in flight. All 64-bit products go
// through one shared 32x32 multiplier; the engine runs a mix and an accumulate
// product per absorbed word, a seed product before it when the word seeds, and
// a final mix product on the last word; a small queue in front lets new requests
// arrive while the engine works and the response register waits on rsp_tready.
module fasthash64_word_stream #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // data_word [63:0], byte_count [67:64], message_length [99:68], zero pad
   input  logic [fh64_pkg::REQ_DATA_W-1:0]     req_tdata,
   // first
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // hash_value [63:0]
   output logic [fh64_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fh64_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [fh64_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [fh64_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import fh64_pkg::*;

   logic [63:0]    seed_ff, seed_in;
   logic           csr_write;

   logic           push_valid, push_ready;
   fh64_entry_type push_entry;
   logic           pop_valid, pop_ready;
   fh64_entry_type pop_entry;

   // csr: zero wait states, seed at address 0, other addresses read as zero
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign seed_in    = (csr_write && csr_paddr == ADDR_SEED) ? csr_pwdata : seed_ff;
   assign csr_prdata = (csr_paddr == ADDR_SEED) ? seed_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   // intake: byte masking and request classification
   fh64_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .data_word      (req_tdata[63:0]),
      .byte_count     (req_tdata[67:64]),
      .first          (req_tuser),
      .last           (req_tlast),
      .message_length (req_tdata[99:68]),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_entry     (push_entry)
   );

   // decoupling queue
   fh64_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // engine: seeding, absorption and final mix, with response register
   fh64_back u_back (
      .clock      (clock),
      .reset      (reset),
      .seed       (seed_ff),
      .q_valid    (pop_valid),
      .q_ready    (pop_ready),
      .q_entry    (pop_entry),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .hash_value (rsp_tdata)
   );

endmodule

@@ hdl/fh64_front.sv @@
// request intake: masks unused bytes and classifies each request
// depends on fh64_pkg
module fh64_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [63:0]            data_word,
   input  logic [3:0]             byte_count,
   input  logic                   first,
   input  logic                   last,
   input  logic [31:0]            message_length,
   output logic                   push_valid,
   input  logic                   push_ready,
   output fh64_pkg::fh64_entry_type push_entry
);
   import fh64_pkg::*;

   logic           valid_ff, valid_in;
   fh64_entry_type entry_ff, entry_in, classified;
   logic [63:0]    byte_mask;
   logic           accept;

   // counts of 8 and above keep the whole word
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         byte_mask[i*8 +: 8] = (byte_count > 4'(i)) ? 8'hFF : 8'h00;
      end
   end

   always_comb begin
      classified.word   = data_word & byte_mask;
      classified.absorb = (byte_count != 4'd0);
      classified.first  = first;
      classified.last   = last;
      classified.length = message_length;
   end

   assign req_ready  = !valid_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign valid_in   = accept || (valid_ff && !push_ready);
   assign entry_in   = accept ? classified : entry_ff;
   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ hdl/fh64_queue.sv @@
// short fifo between request intake and hash engine
// depends on fh64_pkg
module fh64_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  fh64_pkg::fh64_entry_type push_entry,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output fh64_pkg::fh64_entry_type pop_entry
);
   import fh64_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   fh64_entry_type slots_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_entry  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hdl/fh64_back.sv @@
// hash engine: sequencer around one shared 32x32 multiplier
// depends on fh64_pkg
module fh64_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [63:0]             seed,
   input  logic                    q_valid,
   output logic                    q_ready,
   input  fh64_pkg::fh64_entry_type q_entry,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [63:0]             hash_value
);
   import fh64_pkg::*;

   function automatic logic [63:0] xs_a(input logic [63:0] x);
      xs_a = x ^ (x >> SHIFT_A);
   endfunction

   function automatic logic [63:0] xs_b(input logic [63:0] x);
      xs_b = x ^ (x >> SHIFT_B);
   endfunction

   fh64_state_type state_ff, state_in;
   logic [1:0]     step_ff, step_in;
   logic [63:0]    word_ff, word_in;
   logic           absorb_ff, absorb_in;
   logic           last_ff, last_in;
   logic [63:0]    acc_ff, acc_in;
   logic [63:0]    opa_ff, opa_in;
   logic [63:0]    prod_ff, prod_in;
   logic           out_valid_ff, out_valid_in;
   logic [63:0]    hash_ff, hash_in;

   logic           mul_state, out_free, fin_stall, mul_done, last_step;
   logic [63:0]    mul_b, mul_p, prod_sum;
   logic [31:0]    mul_x, mul_y;

   // low 64 bits of a*b as lo*lo + ((lo*hi + hi*lo) << 32), one partial product a cycle unless the final mix stalls
   assign mul_state = (state_ff inside {ST_SEED, ST_MIX, ST_ACC, ST_FIN});
   assign last_step = (step_ff == 2'd2);
   assign out_free  = !out_valid_ff || rsp_ready;
   assign fin_stall = (state_ff == ST_FIN) && last_step && !out_free;
   assign mul_done  = mul_state && last_step && !fin_stall;

   assign mul_b = (state_ff == ST_SEED || state_ff == ST_ACC) ? HASH_M : HASH_MIXK;
   assign mul_x = (step_ff == 2'd2) ? opa_ff[63:32] : opa_ff[31:0];
   assign mul_y = (step_ff == 2'd1) ? mul_b[63:32] : mul_b[31:0];
   assign mul_p = 64'(mul_x) * 64'(mul_y);
   assign prod_sum = (step_ff == 2'd0) ? mul_p : prod_ff + {mul_p[31:0], 32'h0};

   assign q_ready = (state_ff == ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_entry.first) begin
                  state_in = ST_SEED;
               end else if (q_entry.absorb) begin
                  state_in = ST_MIX;
               end else if (q_entry.last) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_SEED: begin
            if (last_step) begin
               if (absorb_ff) begin
                  state_in = ST_MIX;
               end else if (last_ff) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MIX: begin
            if (last_step) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (last_step) begin
               state_in = last_ff ? ST_FIN : ST_IDLE;
            end
         end
         ST_FIN: begin
            if (mul_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      step_in   = 2'd0;
      word_in   = word_ff;
      absorb_in = absorb_ff;
      last_in   = last_ff;
      acc_in    = acc_ff;
      opa_in    = opa_ff;
      hash_in   = hash_ff;
      prod_in   = (mul_state && !fin_stall) ? prod_sum : prod_ff;
      if (mul_state) begin
         step_in = last_step ? (fin_stall ? 2'd2 : 2'd0) : step_ff + 2'd1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               word_in   = q_entry.word;
               absorb_in = q_entry.absorb;
               last_in   = q_entry.last;
               if (q_entry.first) begin
                  opa_in = {32'h0, q_entry.length};
               end else if (q_entry.absorb) begin
                  opa_in = xs_a(q_entry.word);
               end else begin
                  opa_in = xs_a(acc_ff);
               end
            end
         end
         ST_SEED: begin
            if (last_step) begin
               acc_in = seed ^ prod_sum;
               opa_in = absorb_ff ? xs_a(word_ff) : xs_a(seed ^ prod_sum);
            end
         end
         ST_MIX: begin
            if (last_step) begin
               opa_in = acc_ff ^ xs_b(prod_sum);
            end
         end
         ST_ACC: begin
            if (last_step) begin
               acc_in = prod_sum;
               opa_in = xs_a(prod_sum);
            end
         end
         ST_FIN: begin
            if (mul_done) begin
               hash_in = xs_b(prod_sum);
            end
         end
         default: begin
            opa_in = opa_ff;
         end
      endcase
      out_valid_in = ((state_ff == ST_FIN) && mul_done) || (out_valid_ff && !rsp_ready);
   end

   assign rsp_valid  = out_valid_ff;
   assign hash_value = hash_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 2'd0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      absorb_ff <= absorb_in;
      last_ff   <= last_in;
      opa_ff    <= opa_in;
      prod_ff   <= prod_in;
      hash_ff   <= hash_in;
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff != 2'd3)
      else $error("multiply step counter out of range");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |-> (state_ff == ST_IDLE && step_ff == 2'd0))
      else $error("queue popped while engine busy");

   a_result_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ST_FIN && step_ff == 2'd2))
      else $error("result appeared without final mix");

   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      fin_stall |=> (state_ff == ST_FIN && step_ff == 2'd2))
      else $error("final mix left while result register full");

endmodule
